// ----- hdl/byte_port_scsi_command_bridge_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte-port SCSI command bridge
// Concurrent assertion shorthands on the block clock and reset.
// ---------------------------------------------------------------------------
`ifndef BYTE_PORT_SCSI_COMMAND_BRIDGE_TOP_MACROS_SVH
`define BYTE_PORT_SCSI_COMMAND_BRIDGE_TOP_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define BPSCB_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion on clk_i / rst_ni.
`define BPSCB_ASSERT(name, prop, msg) \
  `BPSCB_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/bpscb_pkg.sv -----
// ---------------------------------------------------------------------------
// bpscb_pkg
// Shared constants, codes and beat types of the SCSI command bridge.
// ---------------------------------------------------------------------------
package bpscb_pkg;

  // Sizing
  localparam int CDB_MAX   = 16;                 // CDB length bound; the 4-bit length field accepts at most 15
  localparam int CDB_DEPTH = 16;                 // CDB store entries
  localparam int CDB_AW    = $clog2(CDB_DEPTH);
  localparam int BUF_DEPTH = 4096;               // data buffer bytes
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int REG_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 20;
  localparam int LEN_W    = 4;
  localparam int CNT_W    = 5;

  localparam logic [POS_W:0]   BUF_DEPTH_EXT = (POS_W+1)'(BUF_DEPTH);
  localparam logic [CNT_W-1:0] CDB_MAX_EXT   = CNT_W'(CDB_MAX);

  // Status byte bits (register 0 read)
  localparam int STAT_BUSY_BIT = 0;
  localparam int STAT_ERR_BIT  = 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GUEST_RD  = 3'd0,
    OP_GUEST_WR  = 3'd1,
    OP_BE_BUF_WR = 3'd2,
    OP_BE_BUF_RD = 3'd3,
    OP_BE_CDB_RD = 3'd4,
    OP_FINISH    = 3'd5
  } opcode_e;

  // Guest register map
  localparam logic [REG_W-1:0] REG_CMD   = 2'd0;
  localparam logic [REG_W-1:0] REG_DATA  = 2'd1;
  localparam logic [REG_W-1:0] REG_IDENT = 2'd2;
  localparam logic [REG_W-1:0] REG_COMPL = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_DIR      = 7'b0000010,
    PH_CDBLEN   = 7'b0000100,
    PH_SIZE_LO  = 7'b0001000,
    PH_SIZE_MID = 7'b0010000,
    PH_CMD      = 7'b0100000,
    PH_READY    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [REG_W-1:0]    reg_index;
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   completion_code;
  } beat_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              command_ready;
    logic              busy_res;
    logic              direction;
    logic [BYTE_W-1:0] target_id;
    logic [LEN_W-1:0]  cdb_length;
    logic [POS_W-1:0]  transfer_length;
  } res_t;

  // Result as it leaves the control stage; read_data comes from the
  // data buffer in the following cycle when use_mem is set.
  typedef struct packed {
    res_t res;
    logic use_mem;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- hdl/bpscb_in_if.sv -----
// ---------------------------------------------------------------------------
// bpscb_in_if
// Command channel: one guest or backend access per beat.
// ---------------------------------------------------------------------------
interface bpscb_in_if;
  logic                                valid;
  logic                                ready;
  logic [bpscb_pkg::OPCODE_W-1:0]      opcode;
  logic [bpscb_pkg::REG_W-1:0]         reg_index;
  logic [bpscb_pkg::BYTE_W-1:0]        data_byte;
  logic [bpscb_pkg::POS_W-1:0]         position;
  logic [bpscb_pkg::BYTE_W-1:0]        completion_code;

  modport source (
    output valid, opcode, reg_index, data_byte, position, completion_code,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_index, data_byte, position, completion_code,
    output ready
  );
endinterface

// ----- hdl/bpscb_out_if.sv -----
// ---------------------------------------------------------------------------
// bpscb_out_if
// Result channel: one result beat per command beat.
// ---------------------------------------------------------------------------
interface bpscb_out_if;
  logic                              valid;
  logic                              ready;
  logic [bpscb_pkg::BYTE_W-1:0]      read_data;
  logic                              command_ready;
  logic                              busy_res;
  logic                              direction;
  logic [bpscb_pkg::BYTE_W-1:0]      target_id;
  logic [bpscb_pkg::LEN_W-1:0]       cdb_length;
  logic [bpscb_pkg::POS_W-1:0]       transfer_length;

  modport source (
    output valid, read_data, command_ready, busy_res, direction, target_id,
           cdb_length, transfer_length,
    input  ready
  );
  modport sink (
    input  valid, read_data, command_ready, busy_res, direction, target_id,
           cdb_length, transfer_length,
    output ready
  );
endinterface

// ----- hdl/byte_port_scsi_command_bridge_top.sv -----
// ---------------------------------------------------------------------------
// byte_port_scsi_command_bridge_top
// Byte-wide four-register SCSI command bridge with a data buffer.
// ---------------------------------------------------------------------------
// Each command beat is one guest register access (read or write of
// registers 0..3) or one backend access (buffer write, buffer read, CDB
// read, request finished), and yields exactly one result beat. A new beat
// is taken every cycle while ready is high. Its result is held in the
// result stage, lined up with the registered read of the data buffer
// RAM, then in the result queue. The command channel drops ready only when
// the result stage and the two-entry result queue are all full and the
// result side is not taking a beat, so the guest is held off only once
// three results are waiting. The data buffer is not cleared after reset;
// reading a byte that was never written returns an unspecified value. The
// CDB store is cleared at once through per-entry valid bits, so no clearing
// pass is needed and the block is usable right out of reset.
// ---------------------------------------------------------------------------
module byte_port_scsi_command_bridge_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpscb_in_if.sink    cmd_i,
  bpscb_out_if.source res_o
);

  bpscb_pkg::beat_in_t beat;
  bpscb_pkg::stage_t   stage;
  bpscb_pkg::mem_req_t mem_req;
  bpscb_pkg::res_t     out_res;
  logic [bpscb_pkg::BYTE_W-1:0] mem_rdata;
  logic                can_accept;
  logic                accept;

  // Command beat payload
  always_comb begin
    beat.opcode          = cmd_i.opcode;
    beat.reg_index       = cmd_i.reg_index;
    beat.data_byte       = cmd_i.data_byte;
    beat.position        = cmd_i.position;
    beat.completion_code = cmd_i.completion_code;
  end

  assign cmd_i.ready = can_accept;
  assign accept      = cmd_i.valid && can_accept;

  // Sequencer and register state: all updates land at the accepting edge
  bpscb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .beat_i    (beat),
    .stage_o   (stage),
    .mem_req_o (mem_req)
  );

  // Data buffer: guest port uses the running position, backend its own index
  bpscb_data_ram #(
    .DEPTH (bpscb_pkg::BUF_DEPTH),
    .WIDTH (bpscb_pkg::BYTE_W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // Result stage lines up with buffer read data, then queues the beat
  bpscb_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .stage_i      (stage),
    .mem_rdata_i  (mem_rdata),
    .pop_ready_i  (res_o.ready),
    .can_accept_o (can_accept),
    .out_valid_o  (res_o.valid),
    .out_res_o    (out_res)
  );

  always_comb begin
    res_o.read_data       = out_res.read_data;
    res_o.command_ready   = out_res.command_ready;
    res_o.busy_res        = out_res.busy_res;
    res_o.direction       = out_res.direction;
    res_o.target_id       = out_res.target_id;
    res_o.cdb_length      = out_res.cdb_length;
    res_o.transfer_length = out_res.transfer_length;
  end

endmodule

// ----- hdl/bpscb_data_ram.sv -----
// ---------------------------------------------------------------------------
// bpscb_data_ram
// Single-port synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module bpscb_data_ram #(
  parameter  int DEPTH = 4096,
  parameter  int WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bpscb_ctrl.sv -----
// ---------------------------------------------------------------------------
// bpscb_ctrl
// Command sequencer, register file and CDB store; issues buffer accesses.
// ---------------------------------------------------------------------------
module bpscb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bpscb_pkg::beat_in_t beat_i,
  output bpscb_pkg::stage_t   stage_o,
  output bpscb_pkg::mem_req_t mem_req_o
);

  localparam int BW = bpscb_pkg::BYTE_W;
  localparam int PW = bpscb_pkg::POS_W;
  localparam int LW = bpscb_pkg::LEN_W;
  localparam int CW = bpscb_pkg::CNT_W;
  localparam int DEPTH = bpscb_pkg::CDB_DEPTH;
  localparam int CAW = bpscb_pkg::CDB_AW;
  localparam int AW = bpscb_pkg::BUF_AW;

  bpscb_pkg::phase_e phase_q, phase_d;
  logic [BW-1:0]     target_q, target_d;
  logic              dir_q, dir_d;
  logic [LW-1:0]     len_q, len_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     left_q, left_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              busy_q, busy_d;
  logic [BW-1:0]     compl_q, compl_d;
  logic [BW-1:0]     ident_q, ident_d;

  logic [BW-1:0]     cdb_q [DEPTH];
  logic [DEPTH-1:0]  cdb_vld_q;

  logic              do_soft, do_end, cdb_we, cdb_clr;
  logic              use_mem, cmd_rdy;
  logic [BW-1:0]     rd;
  logic [PW-1:0]     sum_mid;
  logic [CW-1:0]     cnt_inc;
  logic [LW-1:0]     len_nib;
  logic [CAW-1:0]    cdb_idx;
  logic              data_rd_ok, buf_in_range, be_in_range;
  bpscb_pkg::mem_req_t mem_req;

  assign sum_mid      = left_q | {4'h0, beat_i.data_byte, 8'h00};
  assign cnt_inc      = cnt_q + CW'(1);
  assign len_nib      = beat_i.data_byte[LW-1:0];
  assign cdb_idx      = beat_i.position[CAW-1:0];
  assign data_rd_ok   = (phase_q == bpscb_pkg::PH_READY) && !dir_q && !busy_q &&
                        (left_q != '0);
  assign buf_in_range = {1'b0, pos_q} < bpscb_pkg::BUF_DEPTH_EXT;
  assign be_in_range  = {1'b0, beat_i.position} < bpscb_pkg::BUF_DEPTH_EXT;

  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    dir_d    = dir_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    pos_d    = pos_q;
    busy_d   = busy_q;
    compl_d  = compl_q;
    ident_d  = ident_q;
    do_soft  = 1'b0;
    do_end   = 1'b0;
    cdb_we   = 1'b0;
    use_mem  = 1'b0;
    cmd_rdy  = 1'b0;
    rd       = '0;
    mem_req  = '0;
    mem_req.wdata = beat_i.data_byte;

    if (accept_i) begin
      case (beat_i.opcode)
        bpscb_pkg::OP_GUEST_RD: begin
          case (beat_i.reg_index)
            bpscb_pkg::REG_CMD: begin
              rd[bpscb_pkg::STAT_BUSY_BIT] = busy_q;
              rd[bpscb_pkg::STAT_ERR_BIT]  = (compl_q != '0);
            end
            bpscb_pkg::REG_DATA: begin
              if (data_rd_ok) begin
                if (buf_in_range) begin
                  use_mem      = 1'b1;
                  mem_req.en   = 1'b1;
                  mem_req.addr = pos_q[AW-1:0];
                end
                pos_d  = pos_q + PW'(1);
                left_d = left_q - PW'(1);
                if (left_q == PW'(1)) begin
                  do_end  = 1'b1;
                  compl_d = '0;
                end
              end
            end
            bpscb_pkg::REG_IDENT: rd = ident_q;
            default:              rd = compl_q;
          endcase
        end

        bpscb_pkg::OP_GUEST_WR: begin
          case (beat_i.reg_index)
            bpscb_pkg::REG_CMD: begin
              case (phase_q)
                bpscb_pkg::PH_IDLE: begin
                  target_d = beat_i.data_byte;
                  phase_d  = bpscb_pkg::PH_DIR;
                end
                bpscb_pkg::PH_DIR: begin
                  if (beat_i.data_byte[BW-1:1] != '0) begin
                    do_soft = 1'b1;
                  end else begin
                    dir_d   = beat_i.data_byte[0];
                    phase_d = bpscb_pkg::PH_CDBLEN;
                  end
                end
                bpscb_pkg::PH_CDBLEN: begin
                  if ((len_nib == '0) || ({1'b0, len_nib} > bpscb_pkg::CDB_MAX_EXT)) begin
                    do_soft = 1'b1;
                  end else begin
                    len_d   = len_nib;
                    left_d  = {beat_i.data_byte[BW-1:LW], 16'h0000};
                    phase_d = bpscb_pkg::PH_SIZE_LO;
                  end
                end
                bpscb_pkg::PH_SIZE_LO: begin
                  left_d  = left_q | {12'h000, beat_i.data_byte};
                  phase_d = bpscb_pkg::PH_SIZE_MID;
                end
                bpscb_pkg::PH_SIZE_MID: begin
                  if ({1'b0, sum_mid} > bpscb_pkg::BUF_DEPTH_EXT) begin
                    do_soft = 1'b1;
                  end else begin
                    left_d  = sum_mid;
                    phase_d = bpscb_pkg::PH_CMD;
                  end
                end
                bpscb_pkg::PH_CMD: begin
                  cdb_we = 1'b1;
                  cnt_d  = cnt_inc;
                  if (cnt_inc >= {1'b0, len_q}) begin
                    phase_d = bpscb_pkg::PH_READY;
                    pos_d   = '0;
                    // reads and empty writes go straight to the backend
                    if (!dir_q || (left_q == '0)) begin
                      busy_d  = 1'b1;
                      compl_d = '0;
                      cmd_rdy = 1'b1;
                    end
                  end
                end
                default: ;  // command already ready: ignored
              endcase
            end
            bpscb_pkg::REG_DATA: begin
              if ((phase_q != bpscb_pkg::PH_READY) || !dir_q) begin
                do_soft = 1'b1;
              end else if (left_q != '0) begin
                if (buf_in_range) begin
                  mem_req.en   = 1'b1;
                  mem_req.we   = 1'b1;
                  mem_req.addr = pos_q[AW-1:0];
                end
                pos_d  = pos_q + PW'(1);
                left_d = left_q - PW'(1);
                if (left_q == PW'(1)) begin
                  busy_d  = 1'b1;
                  compl_d = '0;
                  cmd_rdy = 1'b1;
                end
              end
            end
            bpscb_pkg::REG_IDENT: ident_d = beat_i.data_byte;
            default:              do_soft = 1'b1;
          endcase
        end

        bpscb_pkg::OP_BE_BUF_WR: begin
          if (be_in_range) begin
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = beat_i.position[AW-1:0];
          end
        end

        bpscb_pkg::OP_BE_BUF_RD: begin
          if (be_in_range) begin
            use_mem      = 1'b1;
            mem_req.en   = 1'b1;
            mem_req.addr = beat_i.position[AW-1:0];
          end
        end

        bpscb_pkg::OP_BE_CDB_RD: begin
          if ((beat_i.position[PW-1:CAW] == '0) && cdb_vld_q[cdb_idx]) begin
            rd = cdb_q[cdb_idx];
          end
        end

        bpscb_pkg::OP_FINISH: begin
          if (busy_q) begin
            if (dir_q || (left_q == '0)) begin
              do_end = 1'b1;
            end
            compl_d = beat_i.completion_code;
            busy_d  = 1'b0;
          end
        end

        default: ;
      endcase
    end

    if (do_end || do_soft) begin
      phase_d  = bpscb_pkg::PH_IDLE;
      target_d = '0;
      len_d    = '0;
      cnt_d    = '0;
      left_d   = '0;
      pos_d    = '0;
    end
    if (do_soft) begin
      dir_d   = 1'b0;
      busy_d  = 1'b0;
      compl_d = '0;
      ident_d = '0;
    end
  end

  assign cdb_clr = do_end || do_soft;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bpscb_pkg::PH_IDLE;
      target_q  <= '0;
      dir_q     <= 1'b0;
      len_q     <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      pos_q     <= '0;
      busy_q    <= 1'b0;
      compl_q   <= '0;
      ident_q   <= '0;
      cdb_vld_q <= '0;
    end else begin
      phase_q  <= phase_d;
      target_q <= target_d;
      dir_q    <= dir_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      busy_q   <= busy_d;
      compl_q  <= compl_d;
      ident_q  <= ident_d;
      if (cdb_clr) begin
        cdb_vld_q <= '0;
      end else if (cdb_we) begin
        cdb_vld_q[cnt_q[CAW-1:0]] <= 1'b1;
      end
    end
  end

  // CDB bytes; an entry without its valid bit reads as zero
  always_ff @(posedge clk_i) begin
    if (cdb_we) begin
      cdb_q[cnt_q[CAW-1:0]] <= beat_i.data_byte;
    end
  end

  always_comb begin
    stage_o.use_mem             = use_mem;
    stage_o.res.read_data       = rd;
    stage_o.res.command_ready   = cmd_rdy;
    stage_o.res.busy_res        = busy_d;
    stage_o.res.direction       = dir_d;
    stage_o.res.target_id       = target_d;
    stage_o.res.cdb_length      = len_d;
    stage_o.res.transfer_length = pos_d + left_d;
  end

  assign mem_req_o = mem_req;

endmodule

// ----- hdl/bpscb_out_queue.sv -----
// ---------------------------------------------------------------------------
// bpscb_out_queue
// Result stage aligned with the buffer read, then a two-entry result queue.
// ---------------------------------------------------------------------------
module bpscb_out_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  bpscb_pkg::stage_t         stage_i,
  input  logic [bpscb_pkg::BYTE_W-1:0] mem_rdata_i,
  input  logic                      pop_ready_i,
  output logic                      can_accept_o,
  output logic                      out_valid_o,
  output bpscb_pkg::res_t           out_res_o
);

  logic              a_vld_q;
  bpscb_pkg::stage_t a_q;
  bpscb_pkg::res_t   a_res;
  bpscb_pkg::res_t   q_mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop, full, a_adv;

  always_comb begin
    a_res = a_q.res;
    if (a_q.use_mem) begin
      a_res.read_data = mem_rdata_i;
    end
  end

  assign pop          = (cnt_q != 2'd0) && pop_ready_i;
  assign full         = (cnt_q == 2'd2);
  assign a_adv        = a_vld_q && (!full || pop);
  assign can_accept_o = !a_vld_q || a_adv;
  assign cnt_d        = cnt_q + {1'b0, a_adv} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        a_vld_q <= 1'b1;
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
      end
      if (a_adv) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      a_q <= stage_i;
    end
    if (a_adv) begin
      q_mem_q[wr_ptr_q] <= a_res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = q_mem_q[rd_ptr_q];

endmodule

// ----- hdl/bpscb_checker.sv -----
// ---------------------------------------------------------------------------
// bpscb_checker
// Port-level checks on the bridge, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "byte_port_scsi_command_bridge_top_macros.svh"

module bpscb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  bpscb_in_if.sink    cmd_i,
  bpscb_out_if.source res_o
);

  // a handed-over command is always outstanding
  `BPSCB_ASSERT(a_handover_busy, (res_o.valid && res_o.command_ready) |-> res_o.busy_res, "command ready without busy")

  // an outstanding request always belongs to a command with a CDB
  `BPSCB_ASSERT(a_busy_has_cdb, (res_o.valid && res_o.busy_res) |-> (res_o.cdb_length != 4'd0), "busy with empty CDB length")

  // with nothing queued the command side never stalls
  `BPSCB_ASSERT(a_empty_takes_beat, !res_o.valid |-> cmd_i.ready, "stall with empty result queue")

  // a stalled result beat holds
  `BPSCB_ASSERT(a_result_holds, (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.read_data) && $stable(res_o.transfer_length)), "stalled result changed")

endmodule

bind byte_port_scsi_command_bridge_top bpscb_checker u_bpscb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cmd_i  (cmd_i),
  .res_o  (res_o)
);

// ----- dv/tb_byte_port_scsi_command_bridge_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_byte_port_scsi_command_bridge_top
// Self-checking bench for the byte-port SCSI command bridge. A cycle-free
// model of the register file, command sequencer and data buffer turns every
// access beat into the result beat the bridge must return. Directed beats
// hit the extremes first; then well-formed read and write commands with
// random content, broken command sequences and random noise follow, under
// random idling on both channels.
// ---------------------------------------------------------------------------
module tb_byte_port_scsi_command_bridge_top;
  import bpscb_pkg::*;

  localparam int RANDOM_BEATS = 1200;   // random part length (ignored opcodes not counted)
  localparam int DRAIN_CYCLES = 20;     // margin after the last owed reply has come back

  // -------------------------------------------------------------------------
  // Clock, reset and channels
  // -------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bpscb_in_if  cmd_if ();
  bpscb_out_if res_if ();

  // Driven copies of the channel inputs, known from time zero.
  logic     drv_valid = 1'b0;
  beat_in_t drv_beat  = '0;
  logic     rcv_ready = 1'b0;

  assign cmd_if.valid           = drv_valid;
  assign cmd_if.opcode          = drv_beat.opcode;
  assign cmd_if.reg_index       = drv_beat.reg_index;
  assign cmd_if.data_byte       = drv_beat.data_byte;
  assign cmd_if.position        = drv_beat.position;
  assign cmd_if.completion_code = drv_beat.completion_code;
  assign res_if.ready           = rcv_ready;

  byte_port_scsi_command_bridge_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // -------------------------------------------------------------------------
  // Bridge model state
  // -------------------------------------------------------------------------
  phase_e            cmd_phase;
  logic [BYTE_W-1:0] cmd_target;
  logic              cmd_to_dev;     // 1: guest writes data to the device
  logic [LEN_W-1:0]  cdb_len;
  logic [CNT_W-1:0]  cdb_cnt;
  logic [POS_W-1:0]  xfer_left;
  logic [POS_W-1:0]  xfer_pos;
  logic              req_busy;
  logic [BYTE_W-1:0] compl_code;
  logic [BYTE_W-1:0] ident_reg;
  logic [BYTE_W-1:0] cdb_mem [CDB_DEPTH];
  logic [BYTE_W-1:0] buf_mem [BUF_DEPTH];
  bit                buf_known [BUF_DEPTH];  // byte written at least once

  beat_in_t access_q [$];   // beats waiting to be driven
  res_t     reply_q  [$];   // replies the bridge owes, oldest first

  int stim_count;
  int cmds_launched;
  int bytes_moved;
  int soft_resets;
  int beats_taken;
  int results_seen;
  int mismatches;

  // Soft reset: everything but the data buffer.
  function automatic void bridge_clear();
    cmd_phase  = PH_IDLE;
    cmd_target = '0;
    cmd_to_dev = 1'b0;
    cdb_len    = '0;
    cdb_cnt    = '0;
    xfer_left  = '0;
    xfer_pos   = '0;
    req_busy   = 1'b0;
    compl_code = '0;
    ident_reg  = '0;
    for (int i = 0; i < CDB_DEPTH; i++) cdb_mem[i] = '0;
    soft_resets++;
  endfunction

  // Command done: direction, busy and completion survive.
  function automatic void command_close();
    cmd_phase  = PH_IDLE;
    cmd_target = '0;
    cdb_len    = '0;
    cdb_cnt    = '0;
    xfer_left  = '0;
    xfer_pos   = '0;
    for (int i = 0; i < CDB_DEPTH; i++) cdb_mem[i] = '0;
  endfunction

  function automatic logic request_launch();
    req_busy   = 1'b1;
    compl_code = '0;
    cmds_launched++;
    return 1'b1;
  endfunction

  // One access beat in, the bridge's reply out.
  function automatic res_t bridge_access(beat_in_t b);
    res_t              r;
    logic [BYTE_W-1:0] rd;
    logic [BYTE_W-1:0] v;
    logic              rdy;
    rd  = '0;
    rdy = 1'b0;
    v   = b.data_byte;
    case (b.opcode)
      OP_GUEST_RD: begin
        case (b.reg_index)
          REG_CMD: begin
            rd[STAT_BUSY_BIT] = req_busy;
            rd[STAT_ERR_BIT]  = |compl_code;
          end
          REG_DATA: begin
            // data only flows out of an idle, ready read command
            if (cmd_phase == PH_READY && !cmd_to_dev && !req_busy && xfer_left != '0) begin
              if (int'(xfer_pos) < BUF_DEPTH) rd = buf_mem[xfer_pos[BUF_AW-1:0]];
              xfer_pos  = xfer_pos + 1'b1;
              xfer_left = xfer_left - 1'b1;
              bytes_moved++;
              if (xfer_left == '0) begin
                command_close();
                compl_code = '0;
              end
            end
          end
          REG_IDENT: rd = ident_reg;
          default:   rd = compl_code;
        endcase
      end
      OP_GUEST_WR: begin
        case (b.reg_index)
          REG_CMD: begin
            case (cmd_phase)
              PH_IDLE: begin
                cmd_target = v;
                cmd_phase  = PH_DIR;
              end
              PH_DIR: begin
                if (v > 8'd1) begin
                  bridge_clear();
                end else begin
                  cmd_to_dev = v[0];
                  cmd_phase  = PH_CDBLEN;
                end
              end
              PH_CDBLEN: begin
                // low nibble: CDB length, high nibble: size bits 19..16
                if (v[3:0] == '0 || int'(v[3:0]) > CDB_MAX) begin
                  bridge_clear();
                end else begin
                  cdb_len   = v[3:0];
                  xfer_left = {v[7:4], 16'h0000};
                  cmd_phase = PH_SIZE_LO;
                end
              end
              PH_SIZE_LO: begin
                xfer_left = xfer_left | {12'h000, v};
                cmd_phase = PH_SIZE_MID;
              end
              PH_SIZE_MID: begin
                xfer_left = xfer_left | {4'h0, v, 8'h00};
                if (int'(xfer_left) > BUF_DEPTH) bridge_clear();
                else cmd_phase = PH_CMD;
              end
              PH_CMD: begin
                cdb_mem[cdb_cnt[CDB_AW-1:0]] = v;
                cdb_cnt = cdb_cnt + 1'b1;
                if (cdb_cnt >= CNT_W'(cdb_len)) begin
                  cmd_phase = PH_READY;
                  xfer_pos  = '0;
                  // reads and empty writes go out as soon as the CDB is in
                  if (!cmd_to_dev || xfer_left == '0) rdy = request_launch();
                end
              end
              default: ;  // command pending: ignored
            endcase
          end
          REG_DATA: begin
            if (cmd_phase != PH_READY || !cmd_to_dev) begin
              bridge_clear();
            end else if (xfer_left != '0) begin
              if (int'(xfer_pos) < BUF_DEPTH) begin
                buf_mem[xfer_pos[BUF_AW-1:0]]   = v;
                buf_known[xfer_pos[BUF_AW-1:0]] = 1'b1;
              end
              xfer_pos  = xfer_pos + 1'b1;
              xfer_left = xfer_left - 1'b1;
              bytes_moved++;
              if (xfer_left == '0) rdy = request_launch();
            end
          end
          REG_IDENT: ident_reg = v;
          default:   bridge_clear();
        endcase
      end
      OP_BE_BUF_WR: begin
        if (int'(b.position) < BUF_DEPTH) begin
          buf_mem[b.position[BUF_AW-1:0]]   = v;
          buf_known[b.position[BUF_AW-1:0]] = 1'b1;
        end
      end
      OP_BE_BUF_RD: begin
        if (int'(b.position) < BUF_DEPTH) rd = buf_mem[b.position[BUF_AW-1:0]];
      end
      OP_BE_CDB_RD: begin
        if (int'(b.position) < CDB_DEPTH) rd = cdb_mem[b.position[CDB_AW-1:0]];
      end
      OP_FINISH: begin
        if (req_busy) begin
          // a read with data keeps its command open for the guest to drain
          if (cmd_to_dev || xfer_left == '0) command_close();
          compl_code = b.completion_code;
          req_busy   = 1'b0;
        end
      end
      default: ;
    endcase
    r.read_data       = rd;
    r.command_ready   = rdy;
    r.busy_res        = req_busy;
    r.direction       = cmd_to_dev;
    r.target_id       = cmd_target;
    r.cdb_length      = cdb_len;
    r.transfer_length = xfer_pos + xfer_left;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Beat builders
  // -------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] rnd8();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] rnd20();
    return POS_W'($urandom);
  endfunction

  function automatic logic [REG_W-1:0] rnd2();
    return REG_W'($urandom);
  endfunction

  // half inside the buffer, half anywhere in the 20-bit space
  function automatic logic [POS_W-1:0] rnd_pos();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, BUF_DEPTH - 1));
    return rnd20();
  endfunction

  function automatic void put(beat_in_t b);
    access_q.push_back(b);
    reply_q.push_back(bridge_access(b));
    if (b.opcode <= OP_FINISH) stim_count++;
  endfunction

  function automatic void access(logic [OPCODE_W-1:0] op, logic [REG_W-1:0] rg,
                                 logic [BYTE_W-1:0] d, logic [POS_W-1:0] p,
                                 logic [BYTE_W-1:0] cc);
    beat_in_t b;
    logic     hole;
    b    = '{opcode: op, reg_index: rg, data_byte: d, position: p, completion_code: cc};
    hole = 1'b0;
    // Buffer bytes never written have no defined value, so any read that
    // would land on one gets a backend write to that byte first.
    if (op == OP_BE_BUF_RD && int'(p) < BUF_DEPTH) begin
      hole = !buf_known[p[BUF_AW-1:0]];
    end else if (op == OP_GUEST_RD && rg == REG_DATA && cmd_phase == PH_READY &&
                 !cmd_to_dev && !req_busy && xfer_left != '0 && int'(xfer_pos) < BUF_DEPTH) begin
      p    = xfer_pos;
      hole = !buf_known[p[BUF_AW-1:0]];
    end
    if (hole) put('{opcode: OP_BE_BUF_WR, reg_index: rnd2(), data_byte: rnd8(),
                    position: p, completion_code: rnd8()});
    put(b);
  endfunction

  function automatic void gw(logic [REG_W-1:0] rg, logic [BYTE_W-1:0] d);
    access(OP_GUEST_WR, rg, d, rnd20(), rnd8());
  endfunction

  function automatic void gr(logic [REG_W-1:0] rg);
    access(OP_GUEST_RD, rg, rnd8(), rnd20(), rnd8());
  endfunction

  // Harmless side traffic that does not disturb a command in flight.
  function automatic void chatter();
    if ($urandom_range(0, 11) != 0) return;
    case ($urandom_range(0, 5))
      0:       gr(REG_CMD);
      1:       gr(REG_IDENT);
      2:       gr(REG_COMPL);
      3:       gw(REG_IDENT, rnd8());
      4:       access(OP_BE_CDB_RD, rnd2(), rnd8(), POS_W'($urandom_range(0, 20)), rnd8());
      default: access(OP_BE_BUF_RD, rnd2(), rnd8(), rnd_pos(), rnd8());
    endcase
  endfunction

  // full-buffer transfers are covered by a directed header below
  function automatic logic [POS_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 70) return POS_W'($urandom_range(1, 8));
    if (r < 92) return POS_W'($urandom_range(9, 64));
    return POS_W'($urandom_range(65, 200));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    if ($urandom_range(0, 3) == 0) return LEN_W'($urandom_range(1, 15));
    return LEN_W'($urandom_range(1, 6));
  endfunction

  // Target, direction, length/size-high, size-low, size-mid, CDB bytes.
  function automatic void command_head(logic to_dev, logic [POS_W-1:0] size,
                                       logic [LEN_W-1:0] len);
    if (cmd_phase != PH_IDLE) gw(REG_COMPL, rnd8());  // drop whatever was half built
    gw(REG_CMD, rnd8());
    gw(REG_CMD, {7'd0, to_dev});
    gw(REG_CMD, {size[19:16], len});
    gw(REG_CMD, size[7:0]);
    gw(REG_CMD, size[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      chatter();
      gw(REG_CMD, rnd8());
    end
  endfunction

  function automatic void read_flow();
    logic [POS_W-1:0]  size;
    logic [BYTE_W-1:0] cc;
    size = pick_size();
    command_head(1'b0, size, pick_len());
    if ($urandom_range(0, 3) == 0) gr(REG_DATA);  // polled while busy: no data
    for (int i = 0; i < int'(size); i++) begin
      chatter();
      access(OP_BE_BUF_WR, rnd2(), rnd8(), POS_W'(i), rnd8());
    end
    if ($urandom_range(0, 19) == 0) begin
      gw(REG_COMPL, rnd8());  // guest gives up before the backend is done
      return;
    end
    cc = ($urandom_range(0, 3) == 0) ? rnd8() : 8'h00;
    access(OP_FINISH, rnd2(), rnd8(), rnd20(), cc);
    for (int i = 0; i < int'(size); i++) begin
      chatter();
      gr(REG_DATA);
    end
  endfunction

  function automatic void write_flow();
    logic [POS_W-1:0]  size;
    logic [BYTE_W-1:0] cc;
    size = pick_size();
    command_head(1'b1, size, pick_len());
    if (size != '0 && $urandom_range(0, 9) == 0) begin
      access(OP_FINISH, rnd2(), rnd8(), rnd20(), rnd8());  // nothing outstanding yet
    end
    for (int i = 0; i < int'(size); i++) begin
      chatter();
      gw(REG_DATA, rnd8());
    end
    if ($urandom_range(0, 4) == 0) gw(REG_DATA, rnd8());  // past the end: dropped
    if ($urandom_range(0, 6) == 0) gw(REG_CMD, rnd8());   // command already out: ignored
    repeat ($urandom_range(0, 3)) begin
      access(OP_BE_BUF_RD, rnd2(), rnd8(), POS_W'($urandom_range(0, int'(size))), rnd8());
    end
    if ($urandom_range(0, 19) == 0) begin
      gw(REG_COMPL, rnd8());
      return;
    end
    cc = ($urandom_range(0, 3) == 0) ? rnd8() : 8'h00;
    access(OP_FINISH, rnd2(), rnd8(), rnd20(), cc);
  endfunction

  // Command sequences that the bridge must throw away.
  function automatic void broken_flow();
    logic [BYTE_W-1:0] hi_len;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] mid;
    if (cmd_phase != PH_IDLE) gw(REG_COMPL, rnd8());
    case ($urandom_range(0, 4))
      0: begin  // direction byte other than 0 or 1
        gw(REG_CMD, rnd8());
        gw(REG_CMD, BYTE_W'($urandom_range(2, 255)));
      end
      1: begin  // zero CDB length
        gw(REG_CMD, rnd8());
        gw(REG_CMD, {7'd0, 1'($urandom)});
        gw(REG_CMD, {4'($urandom), 4'h0});
      end
      2: begin  // transfer larger than the buffer
        hi_len = {4'($urandom), LEN_W'($urandom_range(1, 15))};
        lo     = rnd8();
        mid    = rnd8();
        if (int'({hi_len[7:4], mid, lo}) <= BUF_DEPTH) begin
          if ($urandom_range(0, 1) == 0) begin
            mid = 8'h10;  // one past the buffer
            lo  = 8'h01;
          end else begin
            mid = BYTE_W'($urandom_range(8'h11, 8'hff));
          end
        end
        gw(REG_CMD, rnd8());
        gw(REG_CMD, {7'd0, 1'($urandom)});
        gw(REG_CMD, hi_len);
        gw(REG_CMD, lo);
        gw(REG_CMD, mid);
      end
      3: begin  // header cut short, then a reset write
        repeat ($urandom_range(1, 5)) gw(REG_CMD, BYTE_W'($urandom_range(0, 1)));
        gw(($urandom_range(0, 1) == 0) ? REG_COMPL : REG_DATA, rnd8());
      end
      default: begin  // data write with no write command ready
        gw(REG_DATA, rnd8());
      end
    endcase
  endfunction

  function automatic void noise();
    access(OPCODE_W'($urandom_range(0, 7)), rnd2(), rnd8(), rnd_pos(), rnd8());
  endfunction

  // -------------------------------------------------------------------------
  // Idling
  // -------------------------------------------------------------------------
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // -------------------------------------------------------------------------
  // Command side: beats change at the falling edge, acceptance is seen at
  // the rising edge.
  // -------------------------------------------------------------------------
  logic cmd_fire = 1'b0;
  int   drv_wait = 0;
  bit   drv_calm = 1'b0;

  always @(posedge clk_i) begin
    cmd_fire <= cmd_if.valid && cmd_if.ready;
    if (cmd_if.valid && cmd_if.ready) beats_taken <= beats_taken + 1;
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) drv_calm <= !drv_calm;  // stretches without gaps
    if (rst_ni && (!drv_valid || cmd_fire)) begin
      if (drv_wait > 0) begin
        drv_valid <= 1'b0;
        drv_wait  <= drv_wait - 1;
      end else if (access_q.size() > 0) begin
        drv_beat  <= access_q.pop_front();
        drv_valid <= 1'b1;
        drv_wait  <= idle_len(drv_calm);
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side: random back-pressure, every accepted beat checked against
  // the oldest owed reply.
  // -------------------------------------------------------------------------
  int rcv_hold = 0;
  bit rcv_calm = 1'b0;

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rcv_calm <= !rcv_calm;
    if (rst_ni) begin
      if (rcv_hold > 0) begin
        rcv_ready <= 1'b0;
        rcv_hold  <= rcv_hold - 1;
      end else begin
        rcv_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) rcv_hold <= idle_len(rcv_calm);
      end
    end
  end

  function automatic void field_check(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch on result %0d: expected 0x%0h, got 0x%0h",
             name, results_seen, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : reply_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (reply_q.size() == 0) begin
        $error("result beat %0d arrived with no reply owed", results_seen);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        field_check("read_data", POS_W'(want.read_data), POS_W'(res_if.read_data));
        field_check("command_ready", POS_W'(want.command_ready), POS_W'(res_if.command_ready));
        field_check("busy_res", POS_W'(want.busy_res), POS_W'(res_if.busy_res));
        field_check("direction", POS_W'(want.direction), POS_W'(res_if.direction));
        field_check("target_id", POS_W'(want.target_id), POS_W'(res_if.target_id));
        field_check("cdb_length", POS_W'(want.cdb_length), POS_W'(res_if.cdb_length));
        field_check("transfer_length", want.transfer_length, res_if.transfer_length);
      end
      results_seen++;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // -------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      buf_mem[i]   = '0;
      buf_known[i] = 1'b0;
    end
    bridge_clear();
    soft_resets   = 0;
    cmds_launched = 0;
    bytes_moved   = 0;
    stim_count    = 0;
    beats_taken   = 0;
    results_seen  = 0;
    mismatches    = 0;

    // Directed: status and scratch registers out of reset.
    gr(REG_CMD);
    gw(REG_IDENT, 8'hff);
    gr(REG_IDENT);
    // Read command to target 0xff, one CDB byte, two data bytes.
    gw(REG_CMD, 8'hff);
    gw(REG_CMD, 8'h00);
    gw(REG_CMD, 8'h01);
    gw(REG_CMD, 8'h02);
    gw(REG_CMD, 8'h00);
    gw(REG_CMD, 8'hab);
    access(OP_BE_CDB_RD, REG_CMD, 8'h00, 20'h00000, 8'h00);
    access(OP_BE_CDB_RD, REG_COMPL, 8'hff, 20'hfffff, 8'hff);  // out of range: 0
    access(OP_BE_BUF_WR, REG_CMD, 8'h00, 20'h00000, 8'h00);
    access(OP_BE_BUF_WR, REG_COMPL, 8'hff, 20'h00001, 8'hff);
    access(OP_BE_BUF_RD, REG_CMD, 8'h00, 20'h00001, 8'h00);
    access(OP_BE_BUF_RD, REG_COMPL, 8'hff, 20'hfffff, 8'hff);  // out of range: 0
    gr(REG_DATA);                                              // still busy
    access(OP_FINISH, REG_CMD, 8'h00, 20'h00000, 8'h00);
    gr(REG_DATA);
    gr(REG_DATA);                                              // last byte ends it
    gr(REG_COMPL);
    access(OP_FINISH, REG_COMPL, 8'hff, 20'hfffff, 8'hff);     // nothing outstanding
    access(3'd6, REG_COMPL, 8'hff, 20'hfffff, 8'hff);
    access(3'd7, REG_CMD, 8'h00, 20'h00000, 8'h00);
    gw(REG_DATA, 8'h5a);                                       // no write command: reset
    gw(REG_COMPL, 8'h00);                                      // explicit reset
    gw(REG_CMD, 8'h55);
    gw(REG_CMD, 8'h02);                                        // bad direction
    // Write command of exactly the buffer size: taken, then dropped.
    gw(REG_CMD, 8'h3c);
    gw(REG_CMD, 8'h01);
    gw(REG_CMD, 8'h01);                                        // one CDB byte
    gw(REG_CMD, 8'h00);
    gw(REG_CMD, 8'h10);
    gw(REG_CMD, 8'h77);
    gr(REG_CMD);
    gw(REG_COMPL, 8'h00);

    // Random: mostly complete commands, mixed with broken ones and noise.
    stim_count = 0;
    while (stim_count < RANDOM_BEATS) begin
      case ($urandom_range(0, 99)) inside
        [0:34]:  read_flow();
        [35:59]: write_flow();
        [60:74]: broken_flow();
        default: repeat ($urandom_range(1, 4)) noise();
      endcase
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every beat is in and every owed reply has come back.
    while (access_q.size() != 0 || drv_valid || reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d access beats, %0d commands handed to the backend, %0d bytes via the data register,",
             beats_taken, cmds_launched, bytes_moved);
    $display("%0d soft resets; %0d result beats checked, %0d mismatches.",
             soft_resets, results_seen, mismatches);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("timeout: %0d replies still owed", reply_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bpscb_pkg.sv
hdl/bpscb_in_if.sv
hdl/bpscb_out_if.sv
hdl/bpscb_data_ram.sv
hdl/bpscb_ctrl.sv
hdl/bpscb_out_queue.sv
hdl/byte_port_scsi_command_bridge_top.sv
hdl/bpscb_checker.sv
dv/tb_byte_port_scsi_command_bridge_top.sv
